FILE: sv/gbn_pkg.sv
// go-back-n sender package: word types, field widths, codes and sequencer states
// used by every module of the go_back_n_sender block; no dependencies
`timescale 1ns / 1ps

package gbn_pkg;

   localparam int FRAME_W = 16;
   localparam int OPND_W  = FRAME_W + 1;
   localparam int WIN_W   = 5;
   localparam int TMO_W   = 8;
   localparam int ACT_W   = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEN        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_ROUNDS = 2'd2;

   localparam logic [FRAME_W-1:0] FRAME_COUNT_RST    = 16'd10;
   localparam logic [WIN_W-1:0]   WIN_LEN_RST        = 5'd4;
   localparam logic [TMO_W-1:0]   TIMEOUT_ROUNDS_RST = 8'd3;

   localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ACK   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ROUND = 2'd2;

   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [FRAME_W-1:0] ack_index;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [FRAME_W-1:0] frame_index;
      logic [FRAME_W-1:0] window_base;
      logic               all_done;
      logic               last;
   } rsp_type;

   // operands and result of the shared add/compare unit
   typedef struct packed {
      logic              sub;
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic [OPND_W-1:0] sum;
      logic              lt;
   } unit_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIM_ADD,
      ST_LIM_MIN,
      ST_LIM_DEC,
      ST_SEND_CHK,
      ST_SEND,
      ST_ACK_LO,
      ST_ACK_HI,
      ST_SLIDE,
      ST_ROUND,
      ST_ROUND_CHK,
      ST_TIMEOUT,
      ST_STATUS
   } state_type;

endpackage

FILE: sv/gbn_unit.sv
// shared 17-bit add/subtract and less-than compare unit
// depends on gbn_pkg for the operand and result structs
`timescale 1ns / 1ps

module gbn_unit
   import gbn_pkg::*;
(
   input  unit_req_type unit_req,
   output unit_rsp_type unit_rsp
);

   always_comb begin
      if (unit_req.sub) begin
         unit_rsp.sum = unit_req.a - unit_req.b;
      end else begin
         unit_rsp.sum = unit_req.a + unit_req.b;
      end
      unit_rsp.lt = (unit_req.a < unit_req.b);
   end

endmodule

FILE: sv/gbn_out.sv
// output register for result words, lets the sequencer push when it is empty or its word is taken
// depends on gbn_pkg for rsp_type
`timescale 1ns / 1ps

module gbn_out
   import gbn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    push_ok,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      push_ok  = !valid_ff || !rsp_stall;
      valid_in = push || (valid_ff && rsp_stall);
      data_in  = push ? push_word : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/gbn_seq.sv
// sequencer and protocol state of the go-back-n sender
// depends on gbn_pkg and drives one gbn_unit for most adds and compares
`timescale 1ns / 1ps

module gbn_seq
   import gbn_pkg::*;
#(
   parameter int MAX_WINDOW = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_word,
   output logic               idle,
   input  logic [FRAME_W-1:0] frame_count,
   input  logic [WIN_W-1:0]   win_len,
   input  logic [TMO_W-1:0]   timeout_rounds,
   input  logic               push_ok,
   output logic               push,
   output rsp_type            push_word
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   state_type             state_ff, state_in;
   logic [FRAME_W-1:0]    base_ff, base_in;
   logic [FRAME_W-1:0]    next_ff, next_in;
   logic [MAX_WINDOW-1:0] acked_ff, acked_in;
   logic [TMO_W-1:0]      round_ff, round_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OPND_W-1:0]     lim_ff, lim_in;
   logic [OPND_W-1:0]     lim_dec_ff, lim_dec_in;
   logic [OPND_W-1:0]     off_ff, off_in;
   logic [FRAME_W-1:0]    ack_ff, ack_in;

   logic [OPND_W-1:0] win_ext;
   logic [OPND_W-1:0] eff_win;
   logic              more;
   unit_req_type      unit_req;
   unit_rsp_type      unit_rsp;

   gbn_unit u_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   // window register clamped to 1..MAX_WINDOW
   always_comb begin
      win_ext = OPND_W'(win_len);
      if (win_ext == '0) begin
         eff_win = OPND_W'(1);
      end else if (win_ext > OPND_W'(MAX_WINDOW)) begin
         eff_win = OPND_W'(MAX_WINDOW);
      end else begin
         eff_win = win_ext;
      end
   end

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      next_in    = next_ff;
      acked_in   = acked_ff;
      round_in   = round_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;
      lim_dec_in = lim_dec_ff;
      off_in     = off_ff;
      ack_in     = ack_ff;
      unit_req   = '0;
      more       = 1'b0;
      push       = 1'b0;
      push_word.kind        = KIND_STATUS;
      push_word.frame_index = '0;
      push_word.window_base = base_ff;
      push_word.all_done    = (base_ff >= frame_count);
      push_word.last        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ack_in = req_word.ack_index;
               cnt_in = '0;
               unique case (req_word.action)
                  ACT_SEND:  state_in = ST_LIM_ADD;
                  ACT_ACK:   state_in = ST_ACK_LO;
                  ACT_ROUND: state_in = ST_SLIDE;
                  default:   state_in = ST_STATUS;
               endcase
            end
         end
         ST_LIM_ADD: begin
            unit_req.a = OPND_W'(base_ff);
            unit_req.b = eff_win;
            lim_in     = unit_rsp.sum;
            state_in   = ST_LIM_MIN;
         end
         ST_LIM_MIN: begin
            unit_req.a = lim_ff;
            unit_req.b = OPND_W'(frame_count);
            if (!unit_rsp.lt) begin
               lim_in = OPND_W'(frame_count);
            end
            state_in = ST_LIM_DEC;
         end
         ST_LIM_DEC: begin
            unit_req.sub = 1'b1;
            unit_req.a   = lim_ff;
            unit_req.b   = OPND_W'(1);
            lim_dec_in   = unit_rsp.sum;
            state_in     = ST_SEND_CHK;
         end
         ST_SEND_CHK: begin
            unit_req.a = OPND_W'(next_ff);
            unit_req.b = lim_ff;
            state_in   = unit_rsp.lt ? ST_SEND : ST_STATUS;
         end
         ST_SEND: begin
            // another frame follows while next + 1 < limit and the burst stays within MAX_WINDOW frames
            unit_req.a = OPND_W'(next_ff);
            unit_req.b = lim_dec_ff;
            more       = unit_rsp.lt && (cnt_ff < CNT_W'(MAX_WINDOW - 1));
            if (push_ok) begin
               push                  = 1'b1;
               push_word.kind        = KIND_FRAME;
               push_word.frame_index = next_ff;
               push_word.last        = !more;
               next_in               = next_ff + FRAME_W'(1);
               cnt_in                = cnt_ff + CNT_W'(1);
               if (!more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ACK_LO: begin
            unit_req.sub = 1'b1;
            unit_req.a   = OPND_W'(ack_ff);
            unit_req.b   = OPND_W'(base_ff);
            off_in       = unit_rsp.sum;
            state_in     = unit_rsp.lt ? ST_STATUS : ST_ACK_HI;
         end
         ST_ACK_HI: begin
            unit_req.a = OPND_W'(ack_ff);
            unit_req.b = OPND_W'(next_ff);
            if (unit_rsp.lt && (off_ff < OPND_W'(MAX_WINDOW))) begin
               acked_in[off_ff[IDX_W-1:0]] = 1'b1;
            end
            state_in = ST_STATUS;
         end
         ST_SLIDE: begin
            // one acknowledged frame leaves the window per cycle
            unit_req.a = OPND_W'(base_ff);
            unit_req.b = OPND_W'(frame_count);
            if (unit_rsp.lt && acked_ff[0]) begin
               base_in  = base_ff + FRAME_W'(1);
               acked_in = acked_ff >> 1;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + TMO_W'(1);
            state_in = ST_ROUND_CHK;
         end
         ST_ROUND_CHK: begin
            unit_req.a = OPND_W'(round_ff);
            unit_req.b = OPND_W'(timeout_rounds);
            if (!unit_rsp.lt) begin
               round_in = '0;
               state_in = ST_TIMEOUT;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_TIMEOUT: begin
            unit_req.a = OPND_W'(base_ff);
            unit_req.b = OPND_W'(next_ff);
            if (unit_rsp.lt) begin
               next_in = base_ff;
            end
            state_in = ST_STATUS;
         end
         ST_STATUS: begin
            if (push_ok) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         next_ff  <= '0;
         acked_ff <= '0;
         round_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         acked_ff <= acked_in;
         round_ff <= round_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff     <= lim_in;
      lim_dec_ff <= lim_dec_in;
      off_ff     <= off_in;
      ack_ff     <= ack_in;
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

FILE: sv/go_back_n_sender.sv
// go-back-n sliding window sender, top level with configuration registers
// depends on gbn_pkg, gbn_seq, gbn_unit and gbn_out
//
//   port group  dir   handshake            word
//   req_        in    req_valid/req_stall  req_type (action, ack_index)
//   rsp_        out   rsp_valid/rsp_stall  rsp_type (kind, frame_index, ...)
//   csr_        in    csr_we               csr_index, csr_wdata
//
// one item at a time, stepped by a sequencer around one shared add/compare unit
// send: ST_LIM_ADD, ST_LIM_MIN, ST_LIM_DEC set the limit, then one frame word per cycle unless stalled
// ack: ST_ACK_LO, then ST_ACK_HI if not below the base; round end: ST_SLIDE, ST_ROUND, ST_ROUND_CHK
// reset is synchronous; config registers return to 10 / 4 / 3
// rsp_stall holds words in the output register and pauses the sequencer
`timescale 1ns / 1ps

module go_back_n_sender
   import gbn_pkg::*;
#(
   parameter int MAX_WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [FRAME_W-1:0] total_ff, total_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [TMO_W-1:0]   tmo_ff, tmo_in;

   logic    idle;
   logic    start;
   logic    push;
   logic    push_ok;
   rsp_type push_word;

   always_comb begin
      total_in = total_ff;
      win_in   = win_ff;
      tmo_in   = tmo_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:    total_in = csr_wdata[FRAME_W-1:0];
            CSR_WIN_LEN:        win_in   = csr_wdata[WIN_W-1:0];
            CSR_TIMEOUT_ROUNDS: tmo_in   = csr_wdata[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= FRAME_COUNT_RST;
         win_ff   <= WIN_LEN_RST;
         tmo_ff   <= TIMEOUT_ROUNDS_RST;
      end else begin
         total_ff <= total_in;
         win_ff   <= win_in;
         tmo_ff   <= tmo_in;
      end
   end

   assign req_stall = !idle;
   assign start     = req_valid && idle;

   gbn_seq #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_word       (req_data),
      .idle           (idle),
      .frame_count    (total_ff),
      .win_len        (win_ff),
      .timeout_rounds (tmo_ff),
      .push_ok        (push_ok),
      .push           (push),
      .push_word      (push_word)
   );

   gbn_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .push_ok   (push_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
